FILE: hw/rtl/pcds_pkg.sv
// Shared types and constants of the pulse-count dimming sequencer.
`timescale 1ns / 1ps

package pcds_pkg;

	localparam int DEF_STEPS = 32;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int HOLD_W = 16;
	localparam int LEVEL_OUT_W = 6;
	localparam int TARGET_W = 8;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PULSE_LOW  = 2'd0;
	localparam logic [1:0] REG_PULSE_HIGH = 2'd1;
	localparam logic [1:0] REG_STARTUP    = 2'd2;
	localparam logic [1:0] REG_SHUTDOWN   = 2'd3;

	localparam logic [HOLD_W-1:0] RST_PULSE_LOW  = 16'd2;
	localparam logic [HOLD_W-1:0] RST_PULSE_HIGH = 16'd2;
	localparam logic [HOLD_W-1:0] RST_STARTUP    = 16'd50;
	localparam logic [HOLD_W-1:0] RST_SHUTDOWN   = 16'd4000;

	typedef enum logic [1:0] {
		SEG_OFF,
		SEG_START,
		SEG_LOW,
		SEG_HIGH
	} seg_t;

	typedef struct packed {
		logic load;
		logic emit;
		seg_t seg;
	} cmd_t;

	typedef struct packed {
		logic tgt_eq_level;
		logic tgt_zero;
		logic tgt_full;
		logic powered;
		logic done;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/pcds_ctrl.sv
// Controller state machine that sequences the segments of one request.
`timescale 1ns / 1ps

module pcds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pcds_pkg::status_t status,
	output pcds_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_OFF,
		S_START,
		S_LOW,
		S_HIGH
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		cmd.seg  = pcds_pkg::SEG_OFF;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_DECIDE: begin
			end
			S_OFF: begin
				cmd.emit = status.out_free;
				cmd.seg  = pcds_pkg::SEG_OFF;
			end
			S_START: begin
				cmd.emit = status.out_free;
				cmd.seg  = pcds_pkg::SEG_START;
			end
			S_LOW: begin
				cmd.emit = status.out_free;
				cmd.seg  = pcds_pkg::SEG_LOW;
			end
			S_HIGH: begin
				cmd.emit = status.out_free;
				cmd.seg  = pcds_pkg::SEG_HIGH;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					priority if (status.tgt_eq_level) begin
						state_q <= S_IDLE;
					end else if (status.tgt_zero) begin
						state_q <= S_OFF;
					end else if (!status.powered) begin
						state_q <= S_START;
					end else begin
						state_q <= S_LOW;
					end
				end
				S_OFF: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_START: begin
					if (status.out_free) begin
						state_q <= status.tgt_full ? S_IDLE : S_LOW;
					end
				end
				S_LOW: begin
					if (status.out_free) begin
						state_q <= S_HIGH;
					end
				end
				S_HIGH: begin
					if (status.out_free) begin
						state_q <= status.done ? S_IDLE : S_LOW;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/pcds_dp.sv
// Datapath: configuration registers, level tracking, step counter and output register.
`timescale 1ns / 1ps

module pcds_dp #(
	parameter int STEPS = pcds_pkg::DEF_STEPS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pcds_pkg::ADDR_W-1:0]         paddr,
	input  logic [pcds_pkg::DATA_W-1:0]         pwdata,
	output logic [pcds_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic [pcds_pkg::TARGET_W-1:0]       target_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                en_level,
	output logic [pcds_pkg::HOLD_W-1:0]         hold_us,
	output logic [pcds_pkg::LEVEL_OUT_W-1:0]    level_now,
	output logic                                last,
	input  pcds_pkg::cmd_t                      cmd,
	output pcds_pkg::status_t                   status
);

	localparam int LVL_W = $clog2(STEPS + 1);
	localparam int CNT_W = $clog2(STEPS);
	localparam int PAIR_W = $clog2(STEPS + 1);
	localparam logic [LVL_W-1:0] STEPS_L = LVL_W'(STEPS);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STEPS - 1);
	localparam logic [PAIR_W-1:0] PAIR_CAP = PAIR_W'(STEPS);

	logic [pcds_pkg::HOLD_W-1:0] pulse_low_q;
	logic [pcds_pkg::HOLD_W-1:0] pulse_high_q;
	logic [pcds_pkg::HOLD_W-1:0] startup_q;
	logic [pcds_pkg::HOLD_W-1:0] shutdown_q;

	logic [LVL_W-1:0]  level_q;
	logic [CNT_W-1:0]  count_q;
	logic [PAIR_W-1:0] pairs_q;
	logic              powered_q;
	logic [LVL_W-1:0]  tgt_q;

	logic                       out_valid_q;
	logic                       en_q;
	logic [pcds_pkg::HOLD_W-1:0] hold_q;
	logic [LVL_W-1:0]           lvl_q;
	logic                       last_q;

	logic                        wr_en;
	logic [1:0]                  reg_idx;
	logic [LVL_W-1:0]            sat_tgt;
	logic [LVL_W-1:0]            reached;
	logic [CNT_W-1:0]            count_next;
	logic                        seg_en;
	logic [pcds_pkg::HOLD_W-1:0] seg_hold;
	logic [LVL_W-1:0]            seg_lvl;
	logic                        seg_last;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			pcds_pkg::REG_PULSE_LOW:  prdata = {16'd0, pulse_low_q};
			pcds_pkg::REG_PULSE_HIGH: prdata = {16'd0, pulse_high_q};
			pcds_pkg::REG_STARTUP:    prdata = {16'd0, startup_q};
			pcds_pkg::REG_SHUTDOWN:   prdata = {16'd0, shutdown_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_low_q  <= pcds_pkg::RST_PULSE_LOW;
			pulse_high_q <= pcds_pkg::RST_PULSE_HIGH;
			startup_q    <= pcds_pkg::RST_STARTUP;
			shutdown_q   <= pcds_pkg::RST_SHUTDOWN;
		end else if (wr_en) begin
			unique case (reg_idx)
				pcds_pkg::REG_PULSE_LOW:  pulse_low_q  <= pwdata[15:0];
				pcds_pkg::REG_PULSE_HIGH: pulse_high_q <= pwdata[15:0];
				pcds_pkg::REG_STARTUP:    startup_q    <= pwdata[15:0];
				pcds_pkg::REG_SHUTDOWN:   shutdown_q   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Requests above the top step saturate to it.
	assign sat_tgt = (target_level > pcds_pkg::TARGET_W'(STEPS)) ?
		STEPS_L : target_level[LVL_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= sat_tgt;
		end
	end

	// A zero counter stands for the full level, which the subtraction gives directly.
	assign reached    = STEPS_L - LVL_W'(count_q);
	assign count_next = (count_q == CNT_MAX) ? '0 : count_q + 1'b1;

	assign status.tgt_eq_level = (tgt_q == level_q);
	assign status.tgt_zero     = (tgt_q == '0);
	assign status.tgt_full     = (tgt_q == STEPS_L);
	assign status.powered      = powered_q;
	assign status.done         = (reached == tgt_q) || (pairs_q >= PAIR_CAP);
	assign status.out_free     = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			count_q   <= '0;
			pairs_q   <= '0;
			powered_q <= 1'b0;
		end else if (cmd.emit) begin
			unique case (cmd.seg)
				pcds_pkg::SEG_OFF: begin
					level_q   <= '0;
					powered_q <= 1'b0;
				end
				pcds_pkg::SEG_START: begin
					level_q   <= tgt_q;
					powered_q <= 1'b1;
					count_q   <= '0;
					pairs_q   <= '0;
				end
				pcds_pkg::SEG_LOW: begin
					level_q <= tgt_q;
					count_q <= count_next;
					pairs_q <= pairs_q + 1'b1;
				end
				pcds_pkg::SEG_HIGH: begin
				end
				default: begin
				end
			endcase
		end else if (cmd.load) begin
			// A new transaction starts its pair count from zero.
			pairs_q <= '0;
		end
	end

	always_comb begin
		seg_en   = 1'b0;
		seg_hold = shutdown_q;
		seg_lvl  = tgt_q;
		seg_last = 1'b0;
		unique case (cmd.seg)
			pcds_pkg::SEG_OFF: begin
				seg_lvl  = '0;
				seg_last = 1'b1;
			end
			pcds_pkg::SEG_START: begin
				seg_en   = 1'b1;
				seg_hold = startup_q;
				seg_last = (tgt_q == STEPS_L);
			end
			pcds_pkg::SEG_LOW: begin
				seg_hold = pulse_low_q;
			end
			pcds_pkg::SEG_HIGH: begin
				seg_en   = 1'b1;
				seg_hold = pulse_high_q;
				seg_last = status.done;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			en_q   <= seg_en;
			hold_q <= seg_hold;
			lvl_q  <= seg_lvl;
			last_q <= seg_last;
		end
	end

	assign out_valid = out_valid_q;
	assign en_level  = en_q;
	assign hold_us   = hold_q;
	assign level_now = pcds_pkg::LEVEL_OUT_W'(lvl_q);
	assign last      = last_q;

endmodule

FILE: hw/rtl/pulse_count_dimming_sequencer.sv
// After a transaction is accepted, its first segment passes the decide state, a segment
// state and the output register. Throughput: one segment per cycle while out_stall is low;
// a transaction's segments (up to 2*STEPS-1 of them) come out one by one, as the controller emits them.
// A request that leaves the level unchanged produces nothing.
// Reset restores the timing registers to 2, 2, 50 and 4000 us and clears level and counter.
`timescale 1ns / 1ps

module pulse_count_dimming_sequencer #(
	parameter int STEPS = pcds_pkg::DEF_STEPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pcds_pkg::ADDR_W-1:0]      paddr,
	input  logic [pcds_pkg::DATA_W-1:0]      pwdata,
	output logic [pcds_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pcds_pkg::TARGET_W-1:0]    target_level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             en_level,
	output logic [pcds_pkg::HOLD_W-1:0]      hold_us,
	output logic [pcds_pkg::LEVEL_OUT_W-1:0] level_now,
	output logic                             last
);

	pcds_pkg::cmd_t    cmd;
	pcds_pkg::status_t status;

	pcds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pcds_dp #(
		.STEPS (STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.target_level (target_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.en_level     (en_level),
		.hold_us      (hold_us),
		.level_now    (level_now),
		.last         (last),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

FILE: dv/tb_pulse_count_dimming_sequencer.sv
// Self-checking testbench for the pulse-count dimming sequencer.
`timescale 1ns / 1ps

module tb_pulse_count_dimming_sequencer;

	localparam int STEPS = pcds_pkg::DEF_STEPS;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic                             en_level;
		logic [pcds_pkg::HOLD_W-1:0]      hold_us;
		logic [pcds_pkg::LEVEL_OUT_W-1:0] level_now;
		logic                             last;
	} segment_t;

	// Tracks the dimmer state and timing registers and holds the
	// segments still owed by the block, oldest first.
	class dimming_scoreboard;
		logic [pcds_pkg::HOLD_W-1:0] pulse_low;
		logic [pcds_pkg::HOLD_W-1:0] pulse_high;
		logic [pcds_pkg::HOLD_W-1:0] startup_hold;
		logic [pcds_pkg::HOLD_W-1:0] shutdown_hold;
		int unsigned                 level;
		int unsigned                 step_count;
		bit                          powered;
		segment_t                    segments_due[$];
		int                          errors;

		function new();
			pulse_low = pcds_pkg::RST_PULSE_LOW;
			pulse_high = pcds_pkg::RST_PULSE_HIGH;
			startup_hold = pcds_pkg::RST_STARTUP;
			shutdown_hold = pcds_pkg::RST_SHUTDOWN;
			level = 0;
			step_count = 0;
			powered = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [pcds_pkg::HOLD_W-1:0] val);
			case (idx)
				pcds_pkg::REG_PULSE_LOW:  pulse_low = val;
				pcds_pkg::REG_PULSE_HIGH: pulse_high = val;
				pcds_pkg::REG_STARTUP:    startup_hold = val;
				pcds_pkg::REG_SHUTDOWN:   shutdown_hold = val;
				default: ;
			endcase
		endfunction

		function void push_segment(bit en, logic [pcds_pkg::HOLD_W-1:0] hold,
			int unsigned lvl, bit fin);
			segment_t s;
			s.en_level = en;
			s.hold_us = hold;
			s.level_now = lvl[pcds_pkg::LEVEL_OUT_W-1:0];
			s.last = fin;
			segments_due.push_back(s);
		endfunction

		function void note_request(logic [pcds_pkg::TARGET_W-1:0] req);
			int unsigned tgt;
			int unsigned reached;
			int unsigned pairs;
			bit finished;
			tgt = (req > STEPS) ? STEPS : req;
			// Requests whose saturated target is the current level change nothing.
			if (tgt == level)
				return;
			if (tgt == 0) begin
				powered = 0;
				level = 0;
				push_segment(1'b0, shutdown_hold, 0, 1'b1);
				return;
			end
			level = tgt;
			if (!powered) begin
				powered = 1;
				step_count = 0;
				push_segment(1'b1, startup_hold, level, tgt == STEPS);
				if (tgt == STEPS)
					return;
			end
			pairs = 0;
			finished = 0;
			while (!finished) begin
				step_count = (step_count + 1) % STEPS;
				reached = STEPS - step_count;
				pairs++;
				push_segment(1'b0, pulse_low, level, 1'b0);
				finished = (reached == tgt) || (pairs >= STEPS);
				push_segment(1'b1, pulse_high, level, finished);
			end
		endfunction

		function void check_segment(segment_t got);
			segment_t want;
			if (segments_due.size() == 0) begin
				$error("unexpected segment: en_level %0d hold_us %0d level_now %0d last %0d",
					got.en_level, got.hold_us, got.level_now, got.last);
				errors++;
				return;
			end
			want = segments_due.pop_front();
			if (got.en_level !== want.en_level) begin
				$error("en_level: expected %0d, got %0d", want.en_level, got.en_level);
				errors++;
			end
			if (got.hold_us !== want.hold_us) begin
				$error("hold_us: expected %0d, got %0d", want.hold_us, got.hold_us);
				errors++;
			end
			if (got.level_now !== want.level_now) begin
				$error("level_now: expected %0d, got %0d", want.level_now, got.level_now);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return segments_due.size();
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [pcds_pkg::ADDR_W-1:0]      paddr;
	logic [pcds_pkg::DATA_W-1:0]      pwdata;
	logic [pcds_pkg::DATA_W-1:0]      prdata;
	logic                             pready;
	logic                             in_valid;
	logic                             in_stall;
	logic [pcds_pkg::TARGET_W-1:0]    target_level;
	logic                             out_valid;
	logic                             out_stall;
	logic                             en_level;
	logic [pcds_pkg::HOLD_W-1:0]      hold_us;
	logic [pcds_pkg::LEVEL_OUT_W-1:0] level_now;
	logic                             last;

	int sender_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	dimming_scoreboard sb;

	pulse_count_dimming_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_level(target_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.en_level(en_level),
		.hold_us(hold_us),
		.level_now(level_now),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		segment_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.en_level = en_level;
			got.hold_us = hold_us;
			got.level_now = level_now;
			got.last = last;
			sb.check_segment(got);
		end
	end

	// Ends the run if neither side completes a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_reg(logic [1:0] idx, logic [pcds_pkg::HOLD_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom_range(65535)), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic write_all(logic [pcds_pkg::HOLD_W-1:0] lo, logic [pcds_pkg::HOLD_W-1:0] hi,
		logic [pcds_pkg::HOLD_W-1:0] st, logic [pcds_pkg::HOLD_W-1:0] sd);
		write_reg(pcds_pkg::REG_PULSE_LOW, lo);
		write_reg(pcds_pkg::REG_PULSE_HIGH, hi);
		write_reg(pcds_pkg::REG_STARTUP, st);
		write_reg(pcds_pkg::REG_SHUTDOWN, sd);
	endtask

	task automatic send_request(logic [pcds_pkg::TARGET_W-1:0] req);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		target_level <= req;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(req);
	endtask

	// Lowers valid and waits until every owed segment has come out, then
	// lets a request that produced no segment finish.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [pcds_pkg::TARGET_W-1:0] pick_target();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return pcds_pkg::TARGET_W'($urandom_range(STEPS, 1));
		else if (roll < 80)
			return '0;
		else if (roll < 90)
			return pcds_pkg::TARGET_W'($urandom_range(255, STEPS + 1));
		else
			return pcds_pkg::TARGET_W'($urandom_range(255));
	endfunction

	task automatic run_random(int count);
		repeat (count) begin
			// Now and then hold back until the block has caught up.
			if ($urandom_range(99) < 4) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_request(pick_target());
		end
	endtask

	initial begin
		logic [pcds_pkg::TARGET_W-1:0] directed[$];
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		target_level = '0;
		sender_idle_pct = 36;
		recv_stall_pct = 64;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Off while off, saturated start, saturated repeat, power cycles,
		// the longest pulse train and the bit extremes of the request.
		directed = {8'd0, 8'd33, 8'd255, 8'd0, 8'd0, 8'd1, 8'd32, 8'd31, 8'd2,
			8'd16, 8'd17, 8'd15, 8'd128, 8'd64, 8'd0, 8'd32, 8'd5, 8'd6, 8'd4,
			8'd200, 8'd1, 8'd3, 8'd0, 8'd7};
		foreach (directed[i])
			send_request(directed[i]);
		drain();

		write_all(16'd1, 16'd1, 16'd1, 16'd1);
		run_random(70);
		drain();

		sender_idle_pct = 64;
		recv_stall_pct = 36;
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(70);
		drain();

		sender_idle_pct = 0;
		recv_stall_pct = 0;
		write_all(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
			16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
		run_random(70);
		drain();

		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/pcds_pkg.sv
hw/rtl/pcds_ctrl.sv
hw/rtl/pcds_dp.sv
hw/rtl/pulse_count_dimming_sequencer.sv
dv/tb_pulse_count_dimming_sequencer.sv
